// ----- rtl/reverse_halton_point_generator_defines.svh -----
// Assertion macros for the reverse Halton point generator.
`ifndef REVERSE_HALTON_POINT_GENERATOR_DEFINES_SVH
`define REVERSE_HALTON_POINT_GENERATOR_DEFINES_SVH

// Same-cycle implication under the active-low reset.
`define RHPG_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication under the active-low reset.
`define RHPG_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/rhpg_pkg.sv -----
// Shared types, constants and prime table of the reverse Halton point generator.
`timescale 1ns / 1ps
`default_nettype none
package rhpg_pkg;

  localparam int unsigned SeedW = 64;
  localparam int unsigned BaseW = 6;
  localparam int unsigned CfgIdxW = 8;
  localparam logic [4:0] DimLim = 5'd16;

  localparam logic [CfgIdxW-1:0] CfgDimCount = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgInitSeed = 8'd1;

  typedef struct packed {
    logic take;
    logic init;
    logic dig_start;
    logic dig_store;
    logic hrn_read;
    logic hrn_start;
    logic hrn_store;
    logic emit;
  } rhpg_cmd_t;

  typedef struct packed {
    logic seed_zero;
    logic quot_zero;
    logic depth_zero;
    logic div_done;
    logic out_free;
    logic is_last;
  } rhpg_sts_t;

  function automatic logic [BaseW-1:0] prime_of(input logic [3:0] idx);
    logic [BaseW-1:0] p;
    case (idx)
      4'd0: p = 6'd2;
      4'd1: p = 6'd3;
      4'd2: p = 6'd5;
      4'd3: p = 6'd7;
      4'd4: p = 6'd11;
      4'd5: p = 6'd13;
      4'd6: p = 6'd17;
      4'd7: p = 6'd19;
      4'd8: p = 6'd23;
      4'd9: p = 6'd29;
      4'd10: p = 6'd31;
      4'd11: p = 6'd37;
      4'd12: p = 6'd41;
      4'd13: p = 6'd43;
      4'd14: p = 6'd47;
      default: p = 6'd53;
    endcase
    return p;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/rhpg_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module rhpg_ram #(
  parameter int unsigned WIDTH = 6,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ----- rtl/rhpg_div.sv -----
// Bit-serial restoring divider by a small base.
`timescale 1ns / 1ps
`default_nettype none
module rhpg_div
  import rhpg_pkg::*;
#(
  parameter int unsigned DW = 64
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [DW-1:0]     dividend_i,
  input  wire logic [BaseW-1:0]  divisor_i,
  output logic                   done_o,
  output logic      [DW-1:0]     quot_o,
  output logic      [BaseW-1:0]  rem_o
);

  localparam int unsigned CW = $clog2(DW + 1);

  logic [DW-1:0]    q_q;
  logic [BaseW-1:0] r_q;
  logic [BaseW-1:0] b_q;
  logic [CW-1:0]    cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [BaseW:0]   trial;
  logic [BaseW:0]   diff;
  logic             ge;

  assign trial = {r_q, q_q[DW-1]};
  assign ge    = trial >= {1'b0, b_q};
  assign diff  = trial - {1'b0, b_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(DW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q_q <= dividend_i;
      r_q <= '0;
      b_q <= divisor_i;
    end else if (busy_q) begin
      q_q <= {q_q[DW-2:0], ge};
      r_q <= ge ? diff[BaseW-1:0] : trial[BaseW-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = q_q;
  assign rem_o  = r_q;

endmodule
`default_nettype wire

// ----- rtl/rhpg_dp.sv -----
// Datapath: configuration, seed counter, digit stack, Horner accumulator, output register.
`timescale 1ns / 1ps
`default_nettype none
module rhpg_dp
  import rhpg_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 32
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire rhpg_cmd_t          cmd_i,
  output rhpg_sts_t               sts_o,
  input  wire logic               sample_last_i,
  input  wire logic               cfg_valid_i,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [SeedW-1:0]   cfg_data_i,
  input  wire logic               out_ready_i,
  output logic                    out_valid_o,
  output logic      [31:0]        coord_value_o,
  output logic      [3:0]         coord_index_o,
  output logic      [SeedW-1:0]   point_seed_o,
  output logic                    last_coord_o,
  output logic                    sample_end_o
);

  localparam int unsigned DW = (SeedW > FRAC_BITS + BaseW) ? SeedW : FRAC_BITS + BaseW;

  logic [4:0]           dim_q;
  logic [SeedW-1:0]     seed_q;
  logic [SeedW-1:0]     pseed_q;
  logic                 slast_q;
  logic [3:0]           idx_q;
  logic [SeedW-1:0]     s_q;
  logic [6:0]           depth_q;
  logic [FRAC_BITS-1:0] acc_q;
  logic                 ovalid_q;
  logic [31:0]          ocoord_q;
  logic [3:0]           oidx_q;
  logic [SeedW-1:0]     oseed_q;
  logic                 olast_q;
  logic                 oend_q;

  logic [4:0]            dim_eff;
  logic [BaseW-1:0]      base;
  logic [BaseW-1:0]      digit;
  logic [BaseW-1:0]      e;
  logic                  div_start;
  logic [DW-1:0]         div_dividend;
  logic                  div_done;
  logic [DW-1:0]         div_quot;
  logic [BaseW-1:0]      div_rem;
  logic [5:0]            raddr;
  logic [FRAC_BITS+31:0] acc_ext;
  logic                  out_free;
  logic                  is_last;

  always_comb begin
    if (dim_q == 5'd0) begin
      dim_eff = 5'd1;
    end else if (dim_q > DimLim) begin
      dim_eff = DimLim;
    end else begin
      dim_eff = dim_q;
    end
  end

  assign base         = prime_of(idx_q);
  assign e            = (digit != '0) ? base - digit : '0;
  assign div_start    = cmd_i.dig_start | cmd_i.hrn_start;
  assign div_dividend = cmd_i.hrn_start ? DW'({e, acc_q}) : DW'(s_q);
  assign raddr        = 6'(depth_q - 7'd1);
  assign acc_ext      = {32'd0, acc_q};
  assign out_free     = !ovalid_q || out_ready_i;
  assign is_last      = ({1'b0, idx_q} + 5'd1) == dim_eff;

  rhpg_div #(.DW(DW)) u_div (
    .clk_i,
    .rst_ni,
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (base),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  rhpg_ram #(.WIDTH(BaseW), .DEPTH(64)) u_stack (
    .clk_i,
    .we_i    (cmd_i.dig_store),
    .waddr_i (depth_q[5:0]),
    .wdata_i (div_rem),
    .raddr_i (raddr),
    .rdata_o (digit)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_q    <= 5'd1;
      seed_q   <= 64'd1;
      idx_q    <= '0;
      depth_q  <= '0;
      acc_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CfgDimCount: dim_q  <= cfg_data_i[4:0];
          CfgInitSeed: seed_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.take) begin
        seed_q <= seed_q + 64'd1;
        idx_q  <= '0;
      end
      if (cmd_i.init) begin
        depth_q <= '0;
        acc_q   <= '0;
      end
      if (cmd_i.dig_store) begin
        depth_q <= depth_q + 7'd1;
      end
      if (cmd_i.hrn_read) begin
        depth_q <= depth_q - 7'd1;
      end
      if (cmd_i.hrn_store) begin
        acc_q <= div_quot[FRAC_BITS-1:0];
      end
      if (cmd_i.emit) begin
        ovalid_q <= 1'b1;
        if (!is_last) begin
          idx_q <= idx_q + 4'd1;
        end
      end else if (out_ready_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      pseed_q <= seed_q;
      slast_q <= sample_last_i;
    end
    if (cmd_i.init) begin
      s_q <= pseed_q;
    end
    if (cmd_i.dig_store) begin
      s_q <= div_quot[SeedW-1:0];
    end
    if (cmd_i.emit) begin
      ocoord_q <= acc_ext[31:0];
      oidx_q   <= idx_q;
      oseed_q  <= pseed_q;
      olast_q  <= is_last;
      oend_q   <= is_last & slast_q;
    end
  end

  assign sts_o.seed_zero  = pseed_q == '0;
  assign sts_o.quot_zero  = div_quot == '0;
  assign sts_o.depth_zero = depth_q == '0;
  assign sts_o.div_done   = div_done;
  assign sts_o.out_free   = out_free;
  assign sts_o.is_last    = is_last;

  assign out_valid_o   = ovalid_q;
  assign coord_value_o = ocoord_q;
  assign coord_index_o = oidx_q;
  assign point_seed_o  = oseed_q;
  assign last_coord_o  = olast_q;
  assign sample_end_o  = oend_q;

endmodule
`default_nettype wire

// ----- rtl/rhpg_ctrl.sv -----
// Controller: sequences digit extraction, Horner evaluation and emission per coordinate.
`timescale 1ns / 1ps
`default_nettype none
module rhpg_ctrl
  import rhpg_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire rhpg_sts_t sts_i,
  output rhpg_cmd_t      cmd_o
);

  typedef enum logic [7:0] {
    StIdle  = 8'b0000_0001,
    StInit  = 8'b0000_0010,
    StDGo   = 8'b0000_0100,
    StDWait = 8'b0000_1000,
    StHRd   = 8'b0001_0000,
    StHGo   = 8'b0010_0000,
    StHWait = 8'b0100_0000,
    StEmit  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d    = StInit;
        end
      end
      StInit: begin
        cmd_o.init = 1'b1;
        state_d    = sts_i.seed_zero ? StEmit : StDGo;
      end
      StDGo: begin
        cmd_o.dig_start = 1'b1;
        state_d         = StDWait;
      end
      StDWait: begin
        if (sts_i.div_done) begin
          cmd_o.dig_store = 1'b1;
          state_d         = sts_i.quot_zero ? StHRd : StDGo;
        end
      end
      StHRd: begin
        cmd_o.hrn_read = 1'b1;
        state_d        = StHGo;
      end
      StHGo: begin
        cmd_o.hrn_start = 1'b1;
        state_d         = StHWait;
      end
      StHWait: begin
        if (sts_i.div_done) begin
          cmd_o.hrn_store = 1'b1;
          state_d         = sts_i.depth_zero ? StEmit : StHRd;
        end
      end
      StEmit: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = sts_i.is_last ? StIdle : StInit;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/reverse_halton_point_generator.sv -----
// Top level of the reverse Halton point generator.
// Usage:
//   Input channel (in_valid_i/in_ready_o, sample_last_i): each item requests one point.
//   Output channel (out_valid_o/out_ready_i): one item per coordinate, in dimension
//   order, with coord_index_o, point_seed_o, last_coord_o and sample_end_o.
//   Config channel (cfg_valid_i/cfg_ready_o): index 0 sets the dimension count,
//   index 1 loads the seed counter. Always ready; write only while idle.
// Pace: one shared bit-serial divider sets the pace.
//   A coordinate with n base digits takes n divisions to extract digits and
//   n Horner divisions. A zero seed skips both and is emitted directly.
// Reset: dimension count 1, seed 1, output empty; the digit stack needs no clear.
// Stall: a finished coordinate waits in the output register; work on the next
//   coordinate continues and stops only when it must emit into a full register.
//   A new point is accepted once the last coordinate sits in the output register.
`timescale 1ns / 1ps
`default_nettype none
module reverse_halton_point_generator
  import rhpg_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 32
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic               sample_last_i,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [SeedW-1:0]   cfg_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic      [31:0]        coord_value_o,
  output logic      [3:0]         coord_index_o,
  output logic      [SeedW-1:0]   point_seed_o,
  output logic                    last_coord_o,
  output logic                    sample_end_o
);

  rhpg_cmd_t cmd;
  rhpg_sts_t sts;

  assign cfg_ready_o = 1'b1;

  rhpg_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .sts_i (sts),
    .cmd_o (cmd)
  );

  rhpg_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk_i,
    .rst_ni,
    .cmd_i (cmd),
    .sts_o (sts),
    .sample_last_i,
    .cfg_valid_i,
    .cfg_index_i,
    .cfg_data_i,
    .out_ready_i,
    .out_valid_o,
    .coord_value_o,
    .coord_index_o,
    .point_seed_o,
    .last_coord_o,
    .sample_end_o
  );

endmodule
`default_nettype wire

// ----- rtl/rhpg_chk.sv -----
// Port-level checker for the reverse Halton point generator, with its bind.
`timescale 1ns / 1ps
`default_nettype none
`include "reverse_halton_point_generator_defines.svh"
module rhpg_chk (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_ready_o,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [31:0] coord_value_o,
  input wire logic [3:0]  coord_index_o,
  input wire logic [63:0] point_seed_o,
  input wire logic        last_coord_o,
  input wire logic        sample_end_o
);

  `RHPG_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(coord_value_o) && $stable(point_seed_o), "output item changed while stalled")
  `RHPG_ASSERT_NOW(a_end_on_last, clk_i, rst_ni, out_valid_o && sample_end_o, last_coord_o, "sample end off the last coordinate")
  `RHPG_ASSERT_NOW(a_idx_range, clk_i, rst_ni, out_valid_o && !last_coord_o, coord_index_o != 4'd15, "coordinate index past the prime table")
  `RHPG_ASSERT_NOW(a_zero_seed, clk_i, rst_ni, out_valid_o && point_seed_o == 64'd0, coord_value_o == 32'd0, "nonzero coordinate for zero seed")
  `RHPG_ASSERT_NOW(a_busy_mid_point, clk_i, rst_ni, out_valid_o && !last_coord_o, !in_ready_o, "item accepted in the middle of a point")

endmodule

bind reverse_halton_point_generator rhpg_chk u_rhpg_chk (.*);
`default_nettype wire
